/* hdl/square_spiral_index_map_unit_macros.svh */
// Assertion helpers for the spiral map RTL.
`ifndef SQUARE_SPIRAL_INDEX_MAP_UNIT_MACROS_SVH
`define SQUARE_SPIRAL_INDEX_MAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define SSIM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define SSIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ssim_pkg.sv */
package ssim_pkg;

  localparam int IDX_W   = 16;
  localparam int COORD_W = 8;
  localparam int RING_W  = 7;
  localparam int ROOT_W  = 8;
  localparam int REM_W   = 9;
  localparam int OFF_W   = 10;
  // Internal ring width: one bit more than the output so ring 128 can be flagged.
  localparam int RINGI_W = 8;

  localparam int MAX_RING     = 127;
  localparam int RING_CAP     = 127;
  localparam int EFF_MAX_RING = (MAX_RING > RING_CAP) ? RING_CAP : MAX_RING;

  // Register stages ahead of the output register.
  localparam int PIPE_DEPTH = 6;

  typedef enum logic {
    CMD_IDX2XY = 1'b0,
    CMD_XY2IDX = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [IDX_W-1:0]           idx;
    logic signed [COORD_W-1:0]  col;
    logic signed [COORD_W-1:0]  row;
    sq_t                        sq;
    logic [RINGI_W-1:0]         ring;
    logic [IDX_W-1:0]           acc;
    logic [OFF_W-1:0]           off;
  } stage_t;

endpackage

/* hdl/ssim_in_if.sv */
interface ssim_in_if;
  logic                                 valid;
  logic                                 ready;
  ssim_pkg::cmd_t                       command;
  logic [ssim_pkg::IDX_W-1:0]           index_in;
  logic signed [ssim_pkg::COORD_W-1:0]  col_in;
  logic signed [ssim_pkg::COORD_W-1:0]  row_in;

  modport source (output valid, command, index_in, col_in, row_in, input ready);
  modport sink   (input valid, command, index_in, col_in, row_in, output ready);
endinterface

/* hdl/ssim_out_if.sv */
interface ssim_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ssim_pkg::IDX_W-1:0]           index_out;
  logic signed [ssim_pkg::COORD_W-1:0]  col_out;
  logic signed [ssim_pkg::COORD_W-1:0]  row_out;
  logic [ssim_pkg::RING_W-1:0]          ring_out;
  logic                                 out_of_range;

  modport source (output valid, index_out, col_out, row_out, ring_out, out_of_range,
                  input ready);
  modport sink   (input valid, index_out, col_out, row_out, ring_out, out_of_range,
                  output ready);
endinterface

/* hdl/square_spiral_index_map_unit.sv */
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   command, index_in, col_in, row_in
// out_ch    out  valid/ready   index_out, col_out, row_out, ring_out, out_of_range
//
// One beat is taken every cycle while the output side keeps up.
// The square root runs two digits per stage over four stages, which sets the depth.
// Reset (rst_n low, synchronous) clears every stage valid and the output valid.
// A stalled output holds its beat; upstream stages keep filling bubbles until full.
`include "square_spiral_index_map_unit_macros.svh"

module square_spiral_index_map_unit (
  input  logic         clk,
  input  logic         rst_n,
  ssim_in_if.sink      in_ch,
  ssim_out_if.source   out_ch
);

  ssim_pkg::stage_t                      pipe_r   [ssim_pkg::PIPE_DEPTH];
  ssim_pkg::stage_t                      pipe_nxt [ssim_pkg::PIPE_DEPTH];
  logic [ssim_pkg::PIPE_DEPTH-1:0]       vld_r;
  logic [ssim_pkg::PIPE_DEPTH:0]         adv;

  logic                                  out_vld_r;
  logic [ssim_pkg::IDX_W-1:0]            idx_out_r, idx_out_nxt;
  logic signed [ssim_pkg::COORD_W-1:0]   col_out_r, col_out_nxt;
  logic signed [ssim_pkg::COORD_W-1:0]   row_out_r, row_out_nxt;
  logic [ssim_pkg::RING_W-1:0]           ring_out_r, ring_out_nxt;
  logic                                  oor_r, oor_nxt;

  // One digit of the restoring square root.
  function automatic ssim_pkg::sq_t sqrt_step(input ssim_pkg::sq_t cur, input logic [1:0] pair);
    logic [ssim_pkg::REM_W+1:0] rem_s;
    logic [ssim_pkg::REM_W+1:0] trial;
    ssim_pkg::sq_t              res;
    rem_s = {cur.rem, pair};
    trial = {1'b0, cur.root, 2'b01};
    if (rem_s >= trial) begin
      res.rem  = ssim_pkg::REM_W'(rem_s - trial);
      res.root = {cur.root[ssim_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_s[ssim_pkg::REM_W-1:0];
      res.root = {cur.root[ssim_pkg::ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Stage k advances when it is empty or its successor advances.
  always_comb begin
    adv[ssim_pkg::PIPE_DEPTH] = !out_vld_r || out_ch.ready;
    for (int k = ssim_pkg::PIPE_DEPTH - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  // Stage 0: capture.
  always_comb begin
    pipe_nxt[0]      = '0;
    pipe_nxt[0].cmd  = in_ch.command;
    pipe_nxt[0].idx  = in_ch.index_in;
    pipe_nxt[0].col  = in_ch.col_in;
    pipe_nxt[0].row  = in_ch.row_in;
  end

  // Stage 1: root digits 7 and 6; ring from coordinate magnitudes.
  always_comb begin
    ssim_pkg::sq_t                    mid;
    logic [ssim_pkg::COORD_W-1:0]     mag_c;
    logic [ssim_pkg::COORD_W-1:0]     mag_r;
    pipe_nxt[1]    = pipe_r[0];
    mid            = sqrt_step(pipe_r[0].sq, pipe_r[0].idx[15:14]);
    pipe_nxt[1].sq = sqrt_step(mid, pipe_r[0].idx[13:12]);
    // The unsigned view of the negated value is right even for -128.
    mag_c = pipe_r[0].col[ssim_pkg::COORD_W-1] ?
            (ssim_pkg::COORD_W'(0) - unsigned'(pipe_r[0].col)) : unsigned'(pipe_r[0].col);
    mag_r = pipe_r[0].row[ssim_pkg::COORD_W-1] ?
            (ssim_pkg::COORD_W'(0) - unsigned'(pipe_r[0].row)) : unsigned'(pipe_r[0].row);
    if (pipe_r[0].cmd == ssim_pkg::CMD_XY2IDX) begin
      pipe_nxt[1].ring = ssim_pkg::RINGI_W'((mag_c > mag_r) ? mag_c : mag_r);
    end else begin
      pipe_nxt[1].ring = '0;
    end
  end

  // Stage 2: root digits 5 and 4; ring base square and offset within the ring.
  always_comb begin
    ssim_pkg::sq_t           mid;
    logic [7:0]              diam;
    logic signed [10:0]      rs;
    logic signed [10:0]      cs;
    logic signed [10:0]      qs;
    logic signed [10:0]      ofs;
    pipe_nxt[2]    = pipe_r[1];
    mid            = sqrt_step(pipe_r[1].sq, pipe_r[1].idx[11:10]);
    pipe_nxt[2].sq = sqrt_step(mid, pipe_r[1].idx[9:8]);
    diam = {pipe_r[1].ring[6:0], 1'b0} - 8'd1;
    rs   = signed'(11'(pipe_r[1].ring));
    cs   = 11'(pipe_r[1].col);
    qs   = 11'(pipe_r[1].row);
    priority if (qs == rs && cs < rs) begin
      ofs = rs + cs;
    end else if (cs == rs && qs > -rs) begin
      ofs = 11'sd3 * rs - qs;
    end else if (qs == -rs && cs > -rs) begin
      ofs = 11'sd5 * rs - cs;
    end else begin
      ofs = 11'sd7 * rs + qs;
    end
    if (pipe_r[1].ring == '0) begin
      pipe_nxt[2].acc = '0;
      pipe_nxt[2].off = '0;
    end else begin
      pipe_nxt[2].acc = ssim_pkg::IDX_W'(diam * diam);
      pipe_nxt[2].off = ssim_pkg::OFF_W'(ofs);
    end
  end

  // Stage 3: root digits 3 and 2; coordinate index sum.
  always_comb begin
    ssim_pkg::sq_t mid;
    pipe_nxt[3]     = pipe_r[2];
    mid             = sqrt_step(pipe_r[2].sq, pipe_r[2].idx[7:6]);
    pipe_nxt[3].sq  = sqrt_step(mid, pipe_r[2].idx[5:4]);
    pipe_nxt[3].acc = pipe_r[2].acc + ssim_pkg::IDX_W'(pipe_r[2].off);
  end

  // Stage 4: root digits 1 and 0.
  always_comb begin
    ssim_pkg::sq_t mid;
    pipe_nxt[4]    = pipe_r[3];
    mid            = sqrt_step(pipe_r[3].sq, pipe_r[3].idx[3:2]);
    pipe_nxt[4].sq = sqrt_step(mid, pipe_r[3].idx[1:0]);
  end

  // Stage 5: ring from the root and offset from the ring start.
  // With idx = s*s + rem, an odd root starts the ring; an even one is 2s-1 past it.
  always_comb begin
    logic [ssim_pkg::ROOT_W-1:0] root;
    pipe_nxt[5] = pipe_r[4];
    root        = pipe_r[4].sq.root;
    if (pipe_r[4].cmd == ssim_pkg::CMD_IDX2XY) begin
      pipe_nxt[5].ring = ssim_pkg::RINGI_W'(({1'b0, root} + 9'd1) >> 1);
      if (root[0] || root == '0) begin
        pipe_nxt[5].off = ssim_pkg::OFF_W'(pipe_r[4].sq.rem);
      end else begin
        pipe_nxt[5].off = ssim_pkg::OFF_W'(pipe_r[4].sq.rem) +
                          ssim_pkg::OFF_W'({root, 1'b0}) - ssim_pkg::OFF_W'(1);
      end
    end
  end

  // Output stage: segment, position and final selection.
  always_comb begin
    logic [10:0]         t2;
    logic [10:0]         t4;
    logic [10:0]         t6;
    logic [10:0]         offw;
    logic [10:0]         pos;
    logic signed [9:0]   rs;
    logic signed [9:0]   ps;
    logic signed [9:0]   colw;
    logic signed [9:0]   roww;
    ssim_pkg::stage_t    p;
    p    = pipe_r[ssim_pkg::PIPE_DEPTH-1];
    t2   = {2'b0, p.ring, 1'b0};
    t4   = {1'b0, p.ring, 2'b0};
    t6   = t2 + t4;
    offw = 11'(p.off);
    rs   = signed'(10'(p.ring));
    priority if (offw >= t6) begin
      pos  = offw - t6;
      ps   = signed'(10'(pos));
      colw = -rs;
      roww = -rs + ps;
    end else if (offw >= t4) begin
      pos  = offw - t4;
      ps   = signed'(10'(pos));
      colw = rs - ps;
      roww = -rs;
    end else if (offw >= t2) begin
      pos  = offw - t2;
      ps   = signed'(10'(pos));
      colw = rs;
      roww = rs - ps;
    end else begin
      pos  = offw;
      ps   = signed'(10'(pos));
      colw = -rs + ps;
      roww = rs;
    end

    oor_nxt      = (p.ring > ssim_pkg::RINGI_W'(ssim_pkg::EFF_MAX_RING));
    ring_out_nxt = ssim_pkg::RING_W'(p.ring);
    if (p.cmd == ssim_pkg::CMD_IDX2XY) begin
      idx_out_nxt = p.idx;
      if (p.ring == '0) begin
        col_out_nxt = '0;
        row_out_nxt = '0;
      end else begin
        col_out_nxt = ssim_pkg::COORD_W'(colw);
        row_out_nxt = ssim_pkg::COORD_W'(roww);
      end
    end else begin
      idx_out_nxt = p.acc;
      col_out_nxt = p.col;
      row_out_nxt = p.row;
    end
    if (oor_nxt) begin
      idx_out_nxt  = '0;
      col_out_nxt  = '0;
      row_out_nxt  = '0;
      ring_out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < ssim_pkg::PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv[ssim_pkg::PIPE_DEPTH]) begin
        out_vld_r <= vld_r[ssim_pkg::PIPE_DEPTH-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ssim_pkg::PIPE_DEPTH; k++) begin
      if (adv[k]) begin
        pipe_r[k] <= (k == 0) ? pipe_nxt[0] : pipe_nxt[k];
      end
    end
    if (adv[ssim_pkg::PIPE_DEPTH]) begin
      idx_out_r  <= idx_out_nxt;
      col_out_r  <= col_out_nxt;
      row_out_r  <= row_out_nxt;
      ring_out_r <= ring_out_nxt;
      oor_r      <= oor_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.index_out    = idx_out_r;
  assign out_ch.col_out      = col_out_r;
  assign out_ch.row_out      = row_out_r;
  assign out_ch.ring_out     = ring_out_r;
  assign out_ch.out_of_range = oor_r;

  `SSIM_ASSERT_NOW(a_oor_zero, out_ch.valid && out_ch.out_of_range,
    out_ch.index_out == '0 && out_ch.col_out == '0 && out_ch.row_out == '0 &&
    out_ch.ring_out == '0, "out of range beat carries nonzero fields")
  `SSIM_ASSERT_NOW(a_center_cell,
    out_ch.valid && !out_ch.out_of_range && out_ch.ring_out == '0,
    out_ch.index_out == '0 && out_ch.col_out == '0 && out_ch.row_out == '0,
    "ring zero beat is not the center cell")
  `SSIM_ASSERT_NOW(a_ring_index,
    out_ch.valid && !out_ch.out_of_range && out_ch.ring_out != '0,
    out_ch.index_out != '0, "nonzero ring beat maps to index zero")
  `SSIM_ASSERT_NOW(a_stall_only_full, !in_ch.ready,
    (&vld_r) && out_vld_r && !out_ch.ready, "input stalled while the pipeline has a bubble")
  `SSIM_ASSERT_NEXT(a_stage_hold, vld_r[0] && !adv[1],
    vld_r[0] && $stable(pipe_r[0]), "first stage lost its beat during a stall")

endmodule
